@@ src/pcbe_pkg.sv @@
`default_nettype none
package pcbe_pkg;

    // Request actions.
    typedef enum logic [2:0] {
        ACT_BEGIN   = 3'd0,
        ACT_KEY     = 3'd1,
        ACT_VALUE   = 3'd2,
        ACT_TRAILER = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    localparam int HDR_BYTES   = 12;
    localparam int CMD_BYTES   = 13;
    localparam int WORD_BYTES  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [6:0] RESTART_SPACING_RST = 7'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  data_byte;
        logic [7:0]  key_len;
        logic [15:0] value_len;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       error;
        logic       block_end;
    } rsp_t;

    // One queued command: a run of stream bytes, or a single error result.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [3:0]                first_idx;
        logic [3:0]                last_idx;
        logic                      error;
        logic                      block_end;
    } cmd_t;

endpackage
`default_nettype wire

@@ src/pcbe_front.sv @@
`default_nettype none
module pcbe_front #(
    parameter int MAX_KEY      = 32,
    parameter int MAX_RESTARTS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr_en,
    input  wire logic [6:0]    cfg_wr_data,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire pcbe_pkg::req_t req,
    input  wire logic          cmd_full,
    output logic               cmd_push,
    output pcbe_pkg::cmd_t     cmd
);
    import pcbe_pkg::*;

    localparam int PW = $clog2(MAX_KEY + 1);
    localparam int KW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int CW = $clog2(MAX_RESTARTS + 1);
    localparam int RW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;

    logic [6:0]    ri_reg;
    logic [7:0]    klen_reg, klen_next;
    logic [15:0]   vlen_reg, vlen_next;
    logic [7:0]    kidx_reg, kidx_next;
    logic [PW-1:0] prev_klen_reg, prev_klen_next;
    logic          hdr_sent_reg, hdr_sent_next;
    logic          skip_reg, skip_next;
    logic [31:0]   offset_reg, offset_next;
    logic [6:0]    rsr_reg, rsr_next;
    logic [CW-1:0] rcount_reg, rcount_next;
    logic [CW-1:0] tidx_reg, tidx_next;
    logic          finished_reg, finished_next;

    logic [7:0]    key_mem [MAX_KEY];
    logic [7:0]    key_rd_reg;
    logic          kw_en;
    logic [KW-1:0] kw_addr;
    logic [KW-1:0] kr_addr;

    logic [31:0]   off_mem [MAX_RESTARTS];
    logic [31:0]   off_rd_reg;
    logic          ow_en;
    logic [RW-1:0] ow_addr;
    logic [RW-1:0] or_addr;

    logic       take;
    logic       active;
    logic [6:0] interval;
    logic       restart;
    logic [7:0] next_cnt;

    // Builds a record header command: shared, unshared and value length words.
    function automatic cmd_t make_hdr(input logic [7:0] shared, input logic [7:0] klen,
                                      input logic [15:0] vlen);
        cmd_t c;
        logic [31:0] w0, w1, w2;
        c = '0;
        w0 = {24'd0, shared};
        w1 = {24'd0, 8'(klen - shared)};
        w2 = {16'd0, vlen};
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            c.bytes[b]     = w0[8*b +: 8];
            c.bytes[b + 4] = w1[8*b +: 8];
            c.bytes[b + 8] = w2[8*b +: 8];
        end
        c.first_idx = 4'd0;
        c.last_idx  = 4'(HDR_BYTES - 1);
        return c;
    endfunction

    assign req_ready = !cmd_full;
    assign take      = req_valid && req_ready;
    assign active    = !skip_reg && (kidx_reg < klen_reg || vlen_reg != 16'd0);
    assign interval  = (ri_reg == 7'd0) ? 7'd1 : ri_reg;
    assign restart   = (rsr_reg == 7'd0) || (rsr_reg >= interval);
    assign next_cnt  = (restart ? 8'd0 : {1'b0, rsr_reg}) + 8'd1;
    assign kr_addr   = kidx_next[KW-1:0];
    assign or_addr   = tidx_next[RW-1:0];

    // Classify the request, update the record state and form the command.
    always_comb
    begin
        klen_next      = klen_reg;
        vlen_next      = vlen_reg;
        kidx_next      = kidx_reg;
        prev_klen_next = prev_klen_reg;
        hdr_sent_next  = hdr_sent_reg;
        skip_next      = skip_reg;
        offset_next    = offset_reg;
        rsr_next       = rsr_reg;
        rcount_next    = rcount_reg;
        tidx_next      = tidx_reg;
        finished_next  = finished_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        kw_en          = 1'b0;
        kw_addr        = kidx_reg[KW-1:0];
        ow_en          = 1'b0;
        ow_addr        = rcount_reg[RW-1:0];
        if (take)
        begin
            case (req.action)
                ACT_BEGIN:
                begin
                    if (active || finished_reg || tidx_reg != '0)
                    begin
                        cmd_push  = 1'b1;
                        cmd.error = 1'b1;
                    end
                    else
                    begin
                        klen_next     = req.key_len;
                        vlen_next     = req.value_len;
                        kidx_next     = 8'd0;
                        hdr_sent_next = 1'b0;
                        skip_next     = 1'b0;
                        if ({1'b0, req.key_len} > 9'(MAX_KEY) ||
                            (restart && rcount_reg >= CW'(MAX_RESTARTS)))
                        begin
                            skip_next = 1'b1;
                            cmd_push  = 1'b1;
                            cmd.error = 1'b1;
                        end
                        else
                        begin
                            if (restart)
                            begin
                                ow_en          = 1'b1;
                                rcount_next    = rcount_reg + 1'b1;
                                prev_klen_next = '0;
                            end
                            rsr_next = (next_cnt >= {1'b0, interval}) ? 7'd0 : next_cnt[6:0];
                            if (req.key_len == 8'd0)
                            begin
                                cmd_push       = 1'b1;
                                cmd            = make_hdr(8'd0, 8'd0, req.value_len);
                                hdr_sent_next  = 1'b1;
                                prev_klen_next = '0;
                                offset_next    = offset_reg + 32'(HDR_BYTES);
                            end
                        end
                    end
                end
                ACT_KEY:
                begin
                    if (!skip_reg)
                    begin
                        if (kidx_reg >= klen_reg || {1'b0, kidx_reg} >= 9'(MAX_KEY))
                        begin
                            cmd_push  = 1'b1;
                            cmd.error = 1'b1;
                        end
                        else
                        begin
                            kidx_next = kidx_reg + 8'd1;
                            if (!hdr_sent_reg && kidx_reg < 8'(prev_klen_reg) &&
                                key_rd_reg == req.data_byte)
                            begin
                                // Matching byte of the shared prefix is dropped.
                                if (kidx_next == klen_reg)
                                begin
                                    cmd_push       = 1'b1;
                                    cmd            = make_hdr(klen_reg, klen_reg, vlen_reg);
                                    hdr_sent_next  = 1'b1;
                                    prev_klen_next = PW'(klen_reg);
                                    offset_next    = offset_reg + 32'(HDR_BYTES);
                                end
                            end
                            else
                            begin
                                cmd_push = 1'b1;
                                kw_en    = 1'b1;
                                if (!hdr_sent_reg)
                                begin
                                    cmd            = make_hdr(kidx_reg, klen_reg, vlen_reg);
                                    hdr_sent_next  = 1'b1;
                                    prev_klen_next = PW'(klen_reg);
                                    offset_next    = offset_reg + 32'(HDR_BYTES + 1);
                                end
                                else
                                begin
                                    cmd.first_idx = 4'(HDR_BYTES);
                                    offset_next   = offset_reg + 32'd1;
                                end
                                cmd.bytes[HDR_BYTES] = req.data_byte;
                                cmd.last_idx         = 4'(HDR_BYTES);
                            end
                        end
                    end
                end
                ACT_VALUE:
                begin
                    if (!skip_reg)
                    begin
                        cmd_push = 1'b1;
                        if (kidx_reg < klen_reg || vlen_reg == 16'd0)
                        begin
                            cmd.error = 1'b1;
                        end
                        else
                        begin
                            vlen_next = vlen_reg - 16'd1;
                            cmd.bytes[0]  = req.data_byte;
                            offset_next   = offset_reg + 32'd1;
                        end
                    end
                end
                ACT_TRAILER:
                begin
                    cmd_push = 1'b1;
                    if (active || finished_reg)
                    begin
                        cmd.error = 1'b1;
                    end
                    else
                    begin
                        skip_next    = 1'b0;
                        cmd.last_idx = 4'(WORD_BYTES - 1);
                        offset_next  = offset_reg + 32'(WORD_BYTES);
                        if (tidx_reg < rcount_reg && tidx_reg < CW'(MAX_RESTARTS))
                        begin
                            for (int b = 0; b < WORD_BYTES; b++)
                            begin
                                cmd.bytes[b] = off_rd_reg[8*b +: 8];
                            end
                            tidx_next = tidx_reg + 1'b1;
                        end
                        else
                        begin
                            cmd.bytes[0]  = 8'(rcount_reg);
                            cmd.block_end = 1'b1;
                            finished_next = 1'b1;
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    klen_next      = '0;
                    vlen_next      = '0;
                    kidx_next      = '0;
                    prev_klen_next = '0;
                    hdr_sent_next  = 1'b0;
                    skip_next      = 1'b0;
                    offset_next    = '0;
                    rsr_next       = '0;
                    rcount_next    = '0;
                    tidx_next      = '0;
                    finished_next  = 1'b0;
                end
                default:
                begin
                    cmd_push  = 1'b1;
                    cmd.error = 1'b1;
                end
            endcase
        end
    end

    // Record and block state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg        <= RESTART_SPACING_RST;
            klen_reg      <= '0;
            vlen_reg      <= '0;
            kidx_reg      <= '0;
            prev_klen_reg <= '0;
            hdr_sent_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            offset_reg    <= '0;
            rsr_reg       <= '0;
            rcount_reg    <= '0;
            tidx_reg      <= '0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ri_reg <= cfg_wr_data;
            end
            klen_reg      <= klen_next;
            vlen_reg      <= vlen_next;
            kidx_reg      <= kidx_next;
            prev_klen_reg <= prev_klen_next;
            hdr_sent_reg  <= hdr_sent_next;
            skip_reg      <= skip_next;
            offset_reg    <= offset_next;
            rsr_reg       <= rsr_next;
            rcount_reg    <= rcount_next;
            tidx_reg      <= tidx_next;
            finished_reg  <= finished_next;
        end
    end

    // Previous key store; the byte for the next key index is fetched ahead.
    always_ff @(posedge clk)
    begin
        if (kw_en)
        begin
            key_mem[kw_addr] <= req.data_byte;
        end
        key_rd_reg <= (kw_en && kw_addr == kr_addr) ? req.data_byte : key_mem[kr_addr];
    end

    // Restart offset table; the entry for the next trailer index is fetched ahead.
    always_ff @(posedge clk)
    begin
        if (ow_en)
        begin
            off_mem[ow_addr] <= offset_reg;
        end
        off_rd_reg <= (ow_en && ow_addr == or_addr) ? offset_reg : off_mem[or_addr];
    end

endmodule
`default_nettype wire

@@ src/pcbe_cmd_fifo.sv @@
`default_nettype none
module pcbe_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pcbe_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output pcbe_pkg::cmd_t      head_cmd
);
    import pcbe_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ src/pcbe_back.sv @@
`default_nettype none
module pcbe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire pcbe_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output pcbe_pkg::rsp_t      rsp
);
    import pcbe_pkg::*;

    logic [3:0] cnt_reg, cnt_next;
    logic       valid_reg;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    logic       load;
    logic [3:0] pos;
    logic       last;

    assign load      = cmd_valid && (!valid_reg || rsp_ready);
    assign pos       = cmd.first_idx + cnt_reg;
    assign last      = cmd.error || (pos == cmd.last_idx);
    assign cmd_pop   = load && last;
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

    // Pick the next stream byte of the head command.
    always_comb
    begin
        cnt_next = cnt_reg;
        rsp_next = rsp_reg;
        if (load)
        begin
            cnt_next = last ? 4'd0 : cnt_reg + 4'd1;
            if (cmd.error)
            begin
                rsp_next.out_byte  = 8'd0;
                rsp_next.error     = 1'b1;
                rsp_next.block_end = 1'b0;
            end
            else
            begin
                rsp_next.out_byte  = cmd.bytes[pos];
                rsp_next.error     = 1'b0;
                rsp_next.block_end = cmd.block_end && last;
            end
        end
    end

    // Output register and byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
`default_nettype wire

@@ src/prefix_compressed_block_encoder.sv @@
// A request's first result byte goes through a queue entry, then the output register.
// One request per cycle is taken while each yields at most one byte and the output is not
// stalled; a header is 12 or 13 bytes and a trailer word 4, sent on the single output byte lane.
// A four-entry command queue absorbs those bursts before requests are held off.
// Reset (rst_n, asynchronous, active low) empties the queue and clears block state;
// the restart spacing register returns to 2.
`default_nettype none
module prefix_compressed_block_encoder #(
    parameter int MAX_KEY      = 32,
    parameter int MAX_RESTARTS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic [6:0]     cfg_wr_data,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire pcbe_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output pcbe_pkg::rsp_t      rsp
);
    import pcbe_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic not_empty;

    // Front end: classify requests and keep record state.
    pcbe_front #(
        .MAX_KEY      (MAX_KEY),
        .MAX_RESTARTS (MAX_RESTARTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .cmd_full    (full),
        .cmd_push    (push),
        .cmd         (push_cmd)
    );

    // Command queue between the two halves.
    pcbe_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    // Back end: serialize commands into stream bytes.
    pcbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

@@ src/pcbe_checker.sv @@
`default_nettype none
module pcbe_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire pcbe_pkg::rsp_t rsp
);
    import pcbe_pkg::*;

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // An error result carries a zero byte.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> rsp.out_byte == 8'd0)
        else $error("error result with nonzero byte");

    // The block end mark is never on an error result.
    a_end_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.block_end |-> !rsp.error)
        else $error("block end on error result");

endmodule

bind prefix_compressed_block_encoder pcbe_checker u_pcbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
